[rtl/core/ltqm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ltqm_pkg;

   localparam int SPEED_W   = 16;
   localparam int DIST_W    = 48;
   localparam int TIME_IN_W = 48;
   localparam int SAT_W     = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 48;

   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_ARMED   = 2'd1;
   localparam logic [1:0] PHASE_RUNNING = 2'd2;

   localparam logic [2:0] EVT_NONE     = 3'd0;
   localparam logic [2:0] EVT_LAUNCHED = 3'd1;
   localparam logic [2:0] EVT_TARGET   = 3'd2;
   localparam logic [2:0] EVT_FINISHED = 3'd3;
   localparam logic [2:0] EVT_BOTH     = 3'd4;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_ARM    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_LAUNCH_SPEED    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_SPEED    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FINISH_DISTANCE = 2'd2;

   localparam logic [SPEED_W-1:0] LAUNCH_SPEED_RST    = 16'd412;
   localparam logic [SPEED_W-1:0] TARGET_SPEED_RST    = 16'd24720;
   localparam logic [DIST_W-1:0]  FINISH_DISTANCE_RST = 48'd370792857600;

   localparam logic [SPEED_W-1:0] TRAP_FACTOR = 16'd40722;
   localparam logic [DIST_W-1:0]  DIST_MAX    = 48'hFFFF_FFFF_FFFF;
   localparam logic [63:0]        SAT_MAX     = 64'h0000_0000_FFFF_FFFF;

   // fixed-width part of a captured item
   typedef struct packed {
      logic               kind;
      logic [SPEED_W-1:0] speed;
      logic [SPEED_W-1:0] trap_speed;
   } sample_type;

endpackage

`default_nettype wire

[rtl/core/ltqm_capture.sv]
`timescale 1ns / 1ps
`default_nettype none

module ltqm_capture #(
   parameter int TIME_BITS = 48
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic                              req_tuser,
   input  wire logic [63:0]                       req_tdata,
   input  wire logic                              advance,
   output logic                                   s1_valid,
   output ltqm_pkg::sample_type                   s1_item,
   output logic [TIME_BITS-1:0]                   s1_now,
   output logic [TIME_BITS+ltqm_pkg::SPEED_W-1:0] s1_product
);
   import ltqm_pkg::*;

   localparam int PROD_W = TIME_BITS + SPEED_W;

   logic                 valid_ff, valid_in;
   sample_type           item_ff, item_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [PROD_W-1:0]    product_ff, product_in;
   logic [TIME_BITS-1:0] last_time_ff, last_time_in;
   logic [TIME_BITS-1:0] dt;
   logic [31:0]          trap_full;
   logic                 take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   // last sample time stands in for the previous running sample: a run
   // always opens with a launch sample, so earlier samples never matter
   always_comb begin
      now_in       = TIME_BITS'(req_tdata[SPEED_W +: TIME_IN_W]);
      dt           = now_in - last_time_ff;
      product_in   = PROD_W'(req_tdata[SPEED_W-1:0]) * PROD_W'(dt);
      trap_full    = 32'(req_tdata[SPEED_W-1:0]) * 32'(TRAP_FACTOR);
      item_in.kind       = req_tuser;
      item_in.speed      = req_tdata[SPEED_W-1:0];
      item_in.trap_speed = trap_full[31:16];
      valid_in     = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
      last_time_in = (take && req_tuser == KIND_SAMPLE) ? now_in : last_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         last_time_ff <= '0;
      end else begin
         valid_ff     <= valid_in;
         last_time_ff <= last_time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff    <= item_in;
         now_ff     <= now_in;
         product_ff <= product_in;
      end
   end

   assign s1_valid   = valid_ff;
   assign s1_item    = item_ff;
   assign s1_now     = now_ff;
   assign s1_product = product_ff;

endmodule

`default_nettype wire

[rtl/core/ltqm_tracker.sv]
`timescale 1ns / 1ps
`default_nettype none

module ltqm_tracker #(
   parameter int TIME_BITS = 48
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic [ltqm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [ltqm_pkg::CSR_DAT_W-1:0]         csr_wdata,
   input  wire logic                                   s1_valid,
   input  wire ltqm_pkg::sample_type                   s1_item,
   input  wire logic [TIME_BITS-1:0]                   s1_now,
   input  wire logic [TIME_BITS+ltqm_pkg::SPEED_W-1:0] s1_product,
   output logic                                        advance,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [87:0]                                 rsp_tdata
);
   import ltqm_pkg::*;

   localparam int PROD_W = TIME_BITS + SPEED_W;
   localparam int SUM_W  = ((PROD_W > DIST_W) ? PROD_W : DIST_W) + 1;

   logic [SPEED_W-1:0]   launch_speed_ff, target_speed_ff;
   logic [DIST_W-1:0]    finish_distance_ff;

   logic                 armed_ff, armed_in;
   logic                 running_ff, running_in;
   logic                 seen_ff, seen_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic [SAT_W-1:0]     target_time_ff, target_time_in;
   logic [SAT_W-1:0]     finish_time_ff, finish_time_in;
   logic [SPEED_W-1:0]   trap_ff, trap_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           phase_ff, phase_in;
   logic [2:0]           event_ff, event_in;

   logic                 load;
   logic [SUM_W-1:0]     sum;
   logic [DIST_W-1:0]    new_dist;
   logic [TIME_BITS-1:0] elapsed;
   logic [SAT_W-1:0]     elapsed_sat;
   logic                 hit_target;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign load    = s1_valid && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         launch_speed_ff    <= LAUNCH_SPEED_RST;
         target_speed_ff    <= TARGET_SPEED_RST;
         finish_distance_ff <= FINISH_DISTANCE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LAUNCH_SPEED:    launch_speed_ff    <= csr_wdata[SPEED_W-1:0];
            CSR_TARGET_SPEED:    target_speed_ff    <= csr_wdata[SPEED_W-1:0];
            CSR_FINISH_DISTANCE: finish_distance_ff <= csr_wdata[DIST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      sum         = SUM_W'(dist_ff) + SUM_W'(s1_product);
      new_dist    = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];
      elapsed     = s1_now - start_ff;
      elapsed_sat = (elapsed > TIME_BITS'(SAT_MAX)) ? '1 : elapsed[SAT_W-1:0];
      hit_target  = !seen_ff && (s1_item.speed >= target_speed_ff);

      armed_in       = armed_ff;
      running_in     = running_ff;
      seen_in        = seen_ff;
      start_in       = start_ff;
      dist_in        = dist_ff;
      target_time_in = target_time_ff;
      finish_time_in = finish_time_ff;
      trap_in        = trap_ff;
      event_in       = EVT_NONE;

      if (s1_item.kind == KIND_ARM) begin
         // abandon any run in progress, keep the last trap speed
         armed_in       = 1'b1;
         running_in     = 1'b0;
         target_time_in = '0;
         finish_time_in = '0;
      end else if (armed_ff && !running_ff) begin
         if (s1_item.speed >= launch_speed_ff) begin
            running_in = 1'b1;
            start_in   = s1_now;
            seen_in    = 1'b0;
            dist_in    = '0;
            event_in   = EVT_LAUNCHED;
         end
      end else if (running_ff) begin
         dist_in = new_dist;
         if (hit_target) begin
            seen_in        = 1'b1;
            target_time_in = elapsed_sat;
            event_in       = EVT_TARGET;
         end
         if (new_dist >= finish_distance_ff) begin
            finish_time_in = elapsed_sat;
            trap_in        = s1_item.trap_speed;
            running_in     = 1'b0;
            armed_in       = 1'b0;
            event_in       = hit_target ? EVT_BOTH : EVT_FINISHED;
         end
      end

      phase_in     = running_in ? PHASE_RUNNING : (armed_in ? PHASE_ARMED : PHASE_IDLE);
      rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff       <= 1'b0;
         running_ff     <= 1'b0;
         seen_ff        <= 1'b0;
         start_ff       <= '0;
         dist_ff        <= '0;
         target_time_ff <= '0;
         finish_time_ff <= '0;
         trap_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            armed_ff       <= armed_in;
            running_ff     <= running_in;
            seen_ff        <= seen_in;
            start_ff       <= start_in;
            dist_ff        <= dist_in;
            target_time_ff <= target_time_in;
            finish_time_ff <= finish_time_in;
            trap_ff        <= trap_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         phase_ff <= phase_in;
         event_ff <= event_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, trap_ff, finish_time_ff, target_time_ff, event_ff, phase_ff};

endmodule

`default_nettype wire

[rtl/core/launch_timer_quarter_mile.sv]
`timescale 1ns / 1ps
`default_nettype none
// Launch timer: measures time to a target speed, and time and trap speed
// over a finish distance, from a stream of speed samples.
//
// req_* carries one item per transaction: tuser is the kind (sample or arm),
// tdata the speed and timestamp. rsp_* returns exactly one result per item:
// phase after the item, event code, target time, finish time, trap speed.
// csr_* writes launch_speed, target_speed and finish_distance; write only
// while no item is in flight.
//
// The capture stage registers the item together with speed times elapsed
// microseconds, then the tracker stage updates the run state and loads the
// result register. Throughput is one item per cycle while rsp_tready is
// high; the state loop (distance add, saturate and finish compare) closes
// within the tracker stage.
//
// Reset clears all run state and restores the register defaults; no result
// is pending afterwards. When rsp_tready is low the result holds, the
// capture stage still takes one more item, then req_tready drops.
module launch_timer_quarter_mile #(
   parameter int TIME_BITS = 48
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic        req_tuser,   // kind
   input  wire logic [63:0] req_tdata,   // speed_kph_q8[15:0], time_us[63:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // phase[1:0], event_res[4:2], target_time_us[36:5], finish_time_us[68:37],
   // trap_speed_mph_q8[84:69], zero pad[87:85]
   output logic [87:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);
   import ltqm_pkg::*;

   logic                         advance;
   logic                         s1_valid;
   sample_type                   s1_item;
   logic [TIME_BITS-1:0]         s1_now;
   logic [TIME_BITS+SPEED_W-1:0] s1_product;

   ltqm_capture #(
      .TIME_BITS(TIME_BITS)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item),
      .s1_now     (s1_now),
      .s1_product (s1_product)
   );

   ltqm_tracker #(
      .TIME_BITS(TIME_BITS)
   ) u_tracker (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .s1_valid   (s1_valid),
      .s1_item    (s1_item),
      .s1_now     (s1_now),
      .s1_product (s1_product),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a finished run always leaves the block idle
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[4:2] == EVT_FINISHED || rsp_tdata[4:2] == EVT_BOTH)
      |-> rsp_tdata[1:0] == PHASE_IDLE)
      else $error("finish event without idle phase");

   // a launch always leaves the block running
   a_launch_running: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4:2] == EVT_LAUNCHED |-> rsp_tdata[1:0] == PHASE_RUNNING)
      else $error("launch event without running phase");

   // full capture stage behind a stalled result must block new items
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      s1_valid && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item accepted into a blocked pipeline");

endmodule

`default_nettype wire
